// ===== hdl/gb3_pkg.sv =====
`timescale 1ns / 1ps

package gb3_pkg;

    localparam int DEF_MAX_SIZE     = 4096;
    localparam int RESET_IMAGE_SIZE = 4096;
    localparam int IMG_SIZE_W       = 13;
    localparam int PIX_W            = 8;
    localparam int POS_OUT_W        = 12;
    localparam int VSUM_W           = 10;
    localparam int SUM_W            = 12;
    localparam int PROD_W           = 25;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int RES_SLOTS        = 4;
    localparam int SLOT_CNT_W       = 3;

    localparam logic REG_IDX_IMAGE_SIZE = 1'b0;

    // floor(x * 7282 / 65536) == floor(x / 9) for x <= 4095
    localparam logic [12:0] RECIP9 = 13'd7282;

    typedef logic [PIX_W-1:0] gb3_pix_t;
    // column of the window, [0] top row .. [2] bottom row
    typedef gb3_pix_t [2:0] gb3_col_t;
    // window, [0] oldest column .. [2] newest column
    typedef gb3_col_t [2:0] gb3_win_t;

    typedef struct packed {
        logic row_low;      // center on bottom window row (last image row)
        logic top_clamp;    // row above center is outside the image
        logic col_right;    // center on newest window column (last image column)
        logic left_clamp;   // column left of center is outside the image
        logic corner;       // four-tap corner kernel, divide by 9
    } gb3_sel_t;

    function automatic gb3_pix_t gb3_div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(RECIP9);
        return prod[23:16];
    endfunction

endpackage

// ===== hdl/gb3_col_cell.sv =====
`timescale 1ns / 1ps

module gb3_col_cell
    import gb3_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift,
    input  gb3_col_t load_col,
    output gb3_col_t held_col
);

    gb3_col_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= load_col;
        end
    end

    assign held_col = col_reg;

endmodule

// ===== hdl/gb3_blur.sv =====
`timescale 1ns / 1ps

module gb3_blur
    import gb3_pkg::*;
(
    input  gb3_win_t          win,
    input  gb3_sel_t          sel,
    output logic [SUM_W-1:0]  sum
);

    gb3_pix_t          tp [3];
    gb3_pix_t          md [3];
    gb3_pix_t          nb [3];
    logic [VSUM_W-1:0] vs [3];
    logic [VSUM_W-1:0] vc [3];
    logic [VSUM_W-1:0] vs_l;
    logic [VSUM_W-1:0] vs_c;
    logic [VSUM_W-1:0] vc_c;
    logic [VSUM_W-1:0] vc_n;
    logic [SUM_W-1:0]  hs;
    logic [SUM_W-1:0]  hc;

    // vertical 1-2-1 and corner 2-1 per column
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            tp[j] = (sel.row_low || sel.top_clamp) ? win[j][1] : win[j][0];
            md[j] = sel.row_low ? win[j][2] : win[j][1];
            nb[j] = sel.row_low ? win[j][1] : win[j][2];
            vs[j] = VSUM_W'(tp[j]) + {1'b0, md[j], 1'b0} + VSUM_W'(win[j][2]);
            vc[j] = {1'b0, md[j], 1'b0} + VSUM_W'(nb[j]);
        end
    end

    assign vs_l = (sel.col_right || sel.left_clamp) ? vs[1] : vs[0];
    assign vs_c = sel.col_right ? vs[2] : vs[1];
    assign vc_c = sel.col_right ? vc[2] : vc[1];
    assign vc_n = sel.col_right ? vc[1] : vc[2];

    assign hs  = SUM_W'(vs_l) + {1'b0, vs_c, 1'b0} + SUM_W'(vs[2]);
    assign hc  = {1'b0, vc_c, 1'b0} + SUM_W'(vc_n);
    assign sum = sel.corner ? hc : hs;

endmodule

// ===== hdl/gaussian_3x3_blur_stream_unit.sv =====
// An accepted input item passes the stage 1, 2 and 3 registers and the output buffer before
// its first result is on the output. Throughput: 1 item per cycle while the output accepts;
// an item that yields k results (2 at the last column or on the last row, 4 at the last pixel)
// stalls the input while the 4-slot output buffer drains one result per cycle down to the last.
// Reset: pipeline, output buffer, window and position cleared, image_size = 4096;
// line stores are not cleared.
`timescale 1ns / 1ps

module gaussian_3x3_blur_stream_unit
    import gb3_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] pixel
    input  logic [0:0]            s_axis_tuser,   // [0] frame_start

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [7:0] value, [19:8] out_row, [31:20] out_col
    output logic [0:0]            m_axis_tuser,   // [0] last_of_frame
    output logic                  m_axis_tlast,   // last_of_run

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int POS_W      = $clog2(MAX_SIZE);
    localparam int RESET_CLMP = (RESET_IMAGE_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_IMAGE_SIZE;
    localparam logic [POS_W-1:0] RESET_NM1 = POS_W'(RESET_CLMP - 1);

    typedef struct packed {
        gb3_sel_t               sel;
        logic [POS_OUT_W-1:0]   row;
        logic [POS_OUT_W-1:0]   col;
        logic                   last_frame;
    } slot_t;

    typedef struct packed {
        gb3_pix_t               value;
        logic [POS_OUT_W-1:0]   row;
        logic [POS_OUT_W-1:0]   col;
        logic                   last_run;
        logic                   last_frame;
    } res_t;

    // configuration
    logic [IMG_SIZE_W-1:0] image_size_reg;
    logic [POS_W-1:0]      nm1_reg;
    logic [POS_W-1:0]      nm1_wr;
    logic [31:0]           wr_ext;
    logic                  cfg_wr;

    // position
    logic [POS_W-1:0]      row_cnt_reg;
    logic [POS_W-1:0]      col_cnt_reg;
    logic [POS_W-1:0]      row_cnt_next;
    logic [POS_W-1:0]      col_cnt_next;
    logic [POS_W-1:0]      r0;
    logic [POS_W-1:0]      c0;
    logic                  pos_rst;

    // handshake
    logic                  adv;
    logic                  accept;
    logic                  buf_take;
    logic                  load;
    logic                  pop;

    // line stores
    gb3_pix_t              line_one_mem [MAX_SIZE];
    gb3_pix_t              line_two_mem [MAX_SIZE];
    gb3_pix_t              one_rd_reg;
    gb3_pix_t              two_rd_reg;

    // stage 1
    logic                  v1_reg;
    gb3_pix_t              pix1_reg;
    logic [POS_W-1:0]      r1_reg;
    logic [POS_W-1:0]      c1_reg;
    gb3_col_t              new_col;
    logic [SLOT_CNT_W-1:0] k1;
    slot_t                 s1_slot [RES_SLOTS];

    // window
    gb3_win_t              win;

    // stage 2
    logic                  v2_reg;
    logic [SLOT_CNT_W-1:0] k2_reg;
    slot_t                 s2_slot_reg [RES_SLOTS];
    logic [SUM_W-1:0]      s2_sum [RES_SLOTS];

    // stage 3
    logic                  v3_reg;
    logic [SLOT_CNT_W-1:0] k3_reg;
    slot_t                 s3_slot_reg [RES_SLOTS];
    logic [SUM_W-1:0]      s3_sum_reg [RES_SLOTS];
    res_t                  res_new [RES_SLOTS];

    // output buffer
    res_t                  out_reg [RES_SLOTS];
    logic [RES_SLOTS-1:0]  ov_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_IMAGE_SIZE);
    assign prdata = (paddr[2] == REG_IDX_IMAGE_SIZE) ? APB_DATA_W'(image_size_reg) : '0;
    assign wr_ext = 32'(pwdata[IMG_SIZE_W-1:0]);

    always_comb
    begin
        if (wr_ext < 32'd2)
        begin
            nm1_wr = POS_W'(1);
        end
        else if (wr_ext > 32'(MAX_SIZE))
        begin
            nm1_wr = POS_W'(MAX_SIZE - 1);
        end
        else
        begin
            nm1_wr = POS_W'(wr_ext - 32'd1);
        end
    end

    // ---------------- handshake ----------------
    assign buf_take      = !ov_reg[0] || (!ov_reg[1] && m_axis_tready);
    assign adv           = !v3_reg || buf_take;
    assign load          = v3_reg && buf_take;
    assign pop           = ov_reg[0] && m_axis_tready;
    assign accept        = s_axis_tvalid && adv;
    assign s_axis_tready = adv;

    // ---------------- position ----------------
    assign pos_rst = s_axis_tuser[0] || (row_cnt_reg > nm1_reg) || (col_cnt_reg > nm1_reg);
    assign r0      = pos_rst ? '0 : row_cnt_reg;
    assign c0      = pos_rst ? '0 : col_cnt_reg;

    always_comb
    begin
        if (c0 == nm1_reg)
        begin
            col_cnt_next = '0;
            row_cnt_next = (r0 == nm1_reg) ? '0 : r0 + POS_W'(1);
        end
        else
        begin
            col_cnt_next = c0 + POS_W'(1);
            row_cnt_next = r0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= IMG_SIZE_W'(RESET_IMAGE_SIZE);
            nm1_reg        <= RESET_NM1;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            image_size_reg <= pwdata[IMG_SIZE_W-1:0];
            nm1_reg        <= nm1_wr;
            row_cnt_reg    <= '0;
            col_cnt_reg    <= '0;
        end
        else if (accept)
        begin
            row_cnt_reg    <= row_cnt_next;
            col_cnt_reg    <= col_cnt_next;
        end
    end

    // ---------------- line stores ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            one_rd_reg        <= line_one_mem[c0];
            two_rd_reg        <= line_two_mem[c0];
            line_one_mem[c0]  <= s_axis_tdata;
        end
        if (adv && v1_reg && (r1_reg != '0))
        begin
            line_two_mem[c1_reg] <= one_rd_reg;
        end
    end

    // ---------------- stage 1 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg <= s_axis_tdata;
            r1_reg   <= r0;
            c1_reg   <= c0;
        end
    end

    assign new_col[0] = (r1_reg >= POS_W'(2)) ? two_rd_reg : '0;
    assign new_col[1] = (r1_reg != '0) ? one_rd_reg : '0;
    assign new_col[2] = pix1_reg;

    always_comb
    begin
        logic  r_is1;
        logic  c_is1;
        logic  r_last;
        logic  c_last;
        logic  any;
        slot_t sa;
        slot_t sb;
        slot_t sc;
        slot_t sd;

        r_is1  = (r1_reg == POS_W'(1));
        c_is1  = (c1_reg == POS_W'(1));
        r_last = (r1_reg == nm1_reg);
        c_last = (c1_reg == nm1_reg);
        any    = (r1_reg != '0) && (c1_reg != '0);

        sa.sel.row_low    = 1'b0;
        sa.sel.top_clamp  = r_is1;
        sa.sel.col_right  = 1'b0;
        sa.sel.left_clamp = c_is1;
        sa.sel.corner     = r_is1 && c_is1;
        sa.row            = POS_OUT_W'(r1_reg - POS_W'(1));
        sa.col            = POS_OUT_W'(c1_reg - POS_W'(1));
        sa.last_frame     = 1'b0;

        sb.sel.row_low    = 1'b0;
        sb.sel.top_clamp  = r_is1;
        sb.sel.col_right  = 1'b1;
        sb.sel.left_clamp = 1'b0;
        sb.sel.corner     = r_is1;
        sb.row            = POS_OUT_W'(r1_reg - POS_W'(1));
        sb.col            = POS_OUT_W'(nm1_reg);
        sb.last_frame     = 1'b0;

        sc.sel.row_low    = 1'b1;
        sc.sel.top_clamp  = 1'b0;
        sc.sel.col_right  = 1'b0;
        sc.sel.left_clamp = c_is1;
        sc.sel.corner     = c_is1;
        sc.row            = POS_OUT_W'(r1_reg);
        sc.col            = POS_OUT_W'(c1_reg - POS_W'(1));
        sc.last_frame     = 1'b0;

        sd.sel.row_low    = 1'b1;
        sd.sel.top_clamp  = 1'b0;
        sd.sel.col_right  = 1'b1;
        sd.sel.left_clamp = 1'b0;
        sd.sel.corner     = 1'b1;
        sd.row            = POS_OUT_W'(r1_reg);
        sd.col            = POS_OUT_W'(nm1_reg);
        sd.last_frame     = 1'b1;

        s1_slot[0] = sa;
        s1_slot[1] = c_last ? sb : sc;
        s1_slot[2] = sc;
        s1_slot[3] = sd;

        if (!any)
        begin
            k1 = SLOT_CNT_W'(0);
        end
        else if (r_last && c_last)
        begin
            k1 = SLOT_CNT_W'(4);
        end
        else if (r_last || c_last)
        begin
            k1 = SLOT_CNT_W'(2);
        end
        else
        begin
            k1 = SLOT_CNT_W'(1);
        end
    end

    // ---------------- window: chain of column cells ----------------
    for (genvar j = 0; j < 3; j++)
    begin : g_win
        gb3_col_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (adv && v1_reg),
            .load_col ((j == 2) ? new_col : win[(j + 1) % 3]),
            .held_col (win[j])
        );
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg && (k1 != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k2_reg      <= k1;
            s2_slot_reg <= s1_slot;
        end
    end

    for (genvar i = 0; i < RES_SLOTS; i++)
    begin : g_blur
        gb3_blur u_blur
        (
            .win (win),
            .sel (s2_slot_reg[i].sel),
            .sum (s2_sum[i])
        );
    end

    // ---------------- stage 3 ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k3_reg      <= k2_reg;
            s3_slot_reg <= s2_slot_reg;
            s3_sum_reg  <= s2_sum;
        end
    end

    always_comb
    begin
        for (int i = 0; i < RES_SLOTS; i++)
        begin
            res_new[i].value      = s3_slot_reg[i].sel.corner ? gb3_div9(s3_sum_reg[i])
                                                              : s3_sum_reg[i][SUM_W-1:4];
            res_new[i].row        = s3_slot_reg[i].row;
            res_new[i].col        = s3_slot_reg[i].col;
            res_new[i].last_run   = (SLOT_CNT_W'(i + 1) == k3_reg);
            res_new[i].last_frame = s3_slot_reg[i].last_frame;
        end
    end

    // ---------------- output buffer: chain of result slots ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= '0;
        end
        else if (load)
        begin
            for (int i = 0; i < RES_SLOTS; i++)
            begin
                ov_reg[i] <= (SLOT_CNT_W'(i) < k3_reg);
            end
        end
        else if (pop)
        begin
            ov_reg <= {1'b0, ov_reg[RES_SLOTS-1:1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res_new;
        end
        else if (pop)
        begin
            for (int i = 0; i < RES_SLOTS - 1; i++)
            begin
                out_reg[i] <= out_reg[i + 1];
            end
        end
    end

    assign m_axis_tvalid   = ov_reg[0];
    assign m_axis_tdata    = {out_reg[0].col, out_reg[0].row, out_reg[0].value};
    assign m_axis_tuser[0] = out_reg[0].last_frame;
    assign m_axis_tlast    = out_reg[0].last_run;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import gb3_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_WAIT     = 5000;
    localparam int MAX_REPORTS  = 30;
    localparam logic [APB_ADDR_W-1:0] ADDR_IMAGE_SIZE = APB_ADDR_W'(4 * REG_IDX_IMAGE_SIZE);

    typedef struct packed {
        logic [PIX_W-1:0]     value;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic                 run_end;
        logic                 frame_end;
    } blur_pix_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;    // [7:0] pixel
    logic [0:0]            s_axis_tuser  = '0;    // [0] frame_start
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;          // [7:0] value, [19:8] out_row, [31:20] out_col
    logic [0:0]            m_axis_tuser;          // [0] last_of_frame
    logic                  m_axis_tlast;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // blur model state
    logic [PIX_W-1:0]      line_old [DEF_MAX_SIZE];
    logic [PIX_W-1:0]      line_new [DEF_MAX_SIZE];
    logic [PIX_W-1:0]      win [3][3];
    int                    pos_row;
    int                    pos_col;
    logic [IMG_SIZE_W-1:0] size_reg;
    blur_pix_t             blur_q [$];

    int                    err_count = 0;
    int                    cycle_cnt = 0;
    int                    stall_left = 0;
    bit                    idle_on = 1'b1;
    blur_pix_t             got_pix;
    blur_pix_t             want_pix;

    always #4 clk = ~clk;

    gaussian_3x3_blur_stream_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    task automatic report_mismatch(input string msg);
        if (err_count < MAX_REPORTS)
            $display("%0t: %s", $time, msg);
        err_count++;
    endtask

    function automatic int side_len();
        if (size_reg < 2)
            return 2;
        if (size_reg > DEF_MAX_SIZE)
            return DEF_MAX_SIZE;
        return int'(size_reg);
    endfunction

    // image pixel (y,x), clamped into the image, from the window ending at (r,c)
    function automatic int win_tap(int y, int x, int r, int c, int n);
        int wr;
        int wc;
        if (y < 0)
            y = 0;
        if (y > n - 1)
            y = n - 1;
        if (x < 0)
            x = 0;
        if (x > n - 1)
            x = n - 1;
        wr = 2 - (r - y);
        wc = 2 - (c - x);
        if (wr < 0 || wr > 2 || wc < 0 || wc > 2)
            return 0;
        return int'(win[wr][wc]);
    endfunction

    function automatic blur_pix_t blur_at(int y, int x, int r, int c, int n);
        int        sum;
        int        yi;
        int        xi;
        int        dy;
        int        dx;
        blur_pix_t res;
        sum = 0;
        if ((y == 0 || y == n - 1) && (x == 0 || x == n - 1))
        begin
            // corner: four in-image taps, weights 4/2/2/1, divide by 9
            yi = (y == 0) ? 1 : n - 2;
            xi = (x == 0) ? 1 : n - 2;
            sum = 4 * win_tap(y, x, r, c, n) + 2 * win_tap(y, xi, r, c, n)
                + 2 * win_tap(yi, x, r, c, n) + win_tap(yi, xi, r, c, n);
            res.value = PIX_W'(sum / 9);
        end
        else
        begin
            for (dy = -1; dy <= 1; dy++)
                for (dx = -1; dx <= 1; dx++)
                    sum += (dy == 0 ? 2 : 1) * (dx == 0 ? 2 : 1)
                         * win_tap(y + dy, x + dx, r, c, n);
            res.value = PIX_W'(sum / 16);
        end
        res.row       = POS_OUT_W'(y);
        res.col       = POS_OUT_W'(x);
        res.run_end   = 1'b0;
        res.frame_end = (y == n - 1) && (x == n - 1);
        return res;
    endfunction

    function automatic void predict_blur(logic [PIX_W-1:0] pix, logic fs);
        int               n;
        int               r;
        int               c;
        int               i;
        logic [PIX_W-1:0] up2_pix;
        logic [PIX_W-1:0] up1_pix;
        blur_pix_t        outs [$];
        n = side_len();
        r = pos_row;
        c = pos_col;
        if (fs || r >= n || c >= n)
        begin
            r = 0;
            c = 0;
        end
        up2_pix = (r >= 2) ? line_old[c] : '0;
        up1_pix = (r >= 1) ? line_new[c] : '0;
        for (i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up2_pix;
        win[1][2] = up1_pix;
        win[2][2] = pix;
        if (r >= 1)
            line_old[c] = line_new[c];
        line_new[c] = pix;

        if (r >= 1 && c >= 1)
            outs.push_back(blur_at(r - 1, c - 1, r, c, n));
        if (r >= 1 && c == n - 1)
            outs.push_back(blur_at(r - 1, n - 1, r, c, n));
        if (r == n - 1)
        begin
            if (c >= 1)
                outs.push_back(blur_at(r, c - 1, r, c, n));
            if (c == n - 1)
                outs.push_back(blur_at(r, n - 1, r, c, n));
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].run_end = 1'b1;
        foreach (outs[k])
            blur_q.push_back(outs[k]);

        c++;
        if (c >= n)
        begin
            c = 0;
            r++;
            if (r >= n)
                r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_blur(pix, fs);
    endtask

    // only while idle: all results in, pipeline given time to empty
    task automatic write_image_size(input logic [IMG_SIZE_W-1:0] size);
        s_axis_tvalid <= 1'b0;
        while (blur_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IMAGE_SIZE;
        pwdata  <= APB_DATA_W'(size);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        size_reg = size;
        pos_row  = 0;
        pos_col  = 0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== APB_DATA_W'(size))
            report_mismatch($sformatf("image_size read %0d, expected %0d", prdata, size));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_size();
        int i;
        // default 4096: a few pixels of the first row, no results yet
        for (i = 0; i < 8; i++)
            send_pixel(rand_pixel(), i == 0);
    endtask

    task automatic test_smallest_size();
        int i;
        write_image_size(0);
        for (i = 0; i < 4; i++)
            send_pixel('1, i == 0);
        // next frame by wrap, no frame_start
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h01, 1'b0);
        send_pixel(8'h80, 1'b0);
        write_image_size(1);
        for (i = 0; i < 4; i++)
            send_pixel(rand_pixel(), 1'b0);
        write_image_size(2);
        for (i = 0; i < 4; i++)
            send_pixel(rand_pixel(), i == 0);
    endtask

    task automatic test_size_three();
        int i;
        write_image_size(3);
        send_pixel(8'h55, 1'b1);
        send_pixel(8'hAA, 1'b0);
        // restart mid-frame, checkerboard of extremes
        for (i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'h00 : 8'hFF, i == 0);
    endtask

    task automatic test_oversize();
        int i;
        write_image_size('1);
        for (i = 0; i < 8; i++)
            send_pixel(rand_pixel(), i == 0);
    endtask

    task automatic test_random_frames();
        int                    ph;
        int                    i;
        logic                  fs;
        logic [IMG_SIZE_W-1:0] sz;
        for (ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 9))
                0: sz = 0;
                1: sz = 1;
                default: sz = IMG_SIZE_W'($urandom_range(2, 9));
            endcase
            write_image_size(sz);
            idle_on = (ph < 7);
            for (i = 0; i < 30; i++)
            begin
                if (pos_row == 0 && pos_col == 0)
                    fs = ($urandom_range(0, 3) != 0);
                else
                    fs = ($urandom_range(0, 19) == 0);
                send_pixel(rand_pixel(), fs);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= $urandom_range(0, 9);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_pix.value     = m_axis_tdata[7:0];
            got_pix.row       = m_axis_tdata[19:8];
            got_pix.col       = m_axis_tdata[31:20];
            got_pix.run_end   = m_axis_tlast;
            got_pix.frame_end = m_axis_tuser[0];
            if (blur_q.size() == 0)
                report_mismatch($sformatf("unexpected item value %0d at (%0d,%0d)",
                                          got_pix.value, got_pix.row, got_pix.col));
            else
            begin
                want_pix = blur_q.pop_front();
                if (got_pix.value !== want_pix.value)
                    report_mismatch($sformatf("value %0d, expected %0d at (%0d,%0d)",
                                              got_pix.value, want_pix.value,
                                              want_pix.row, want_pix.col));
                if (got_pix.row !== want_pix.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              got_pix.row, want_pix.row));
                if (got_pix.col !== want_pix.col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              got_pix.col, want_pix.col));
                if (got_pix.run_end !== want_pix.run_end)
                    report_mismatch($sformatf("tlast %0b, expected %0b at (%0d,%0d)",
                                              got_pix.run_end, want_pix.run_end,
                                              want_pix.row, want_pix.col));
                if (got_pix.frame_end !== want_pix.frame_end)
                    report_mismatch($sformatf("last_of_frame %0b, expected %0b at (%0d,%0d)",
                                              got_pix.frame_end, want_pix.frame_end,
                                              want_pix.row, want_pix.col));
            end
        end
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("[gaussian_3x3_blur_stream_unit] ERROR");
        $finish;
    end

    initial
    begin
        int i;
        int j;
        int wait_cnt;
        for (i = 0; i < DEF_MAX_SIZE; i++)
        begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                win[i][j] = '0;
        pos_row  = 0;
        pos_col  = 0;
        size_reg = IMG_SIZE_W'(RESET_IMAGE_SIZE);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_size();
        test_smallest_size();
        test_size_three();
        test_oversize();
        test_random_frames();

        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        while (blur_q.size() != 0 && wait_cnt < END_WAIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (blur_q.size() != 0)
            report_mismatch($sformatf("%0d results never came out", blur_q.size()));
        if (err_count == 0)
            $display("[gaussian_3x3_blur_stream_unit] OK");
        else
            $display("[gaussian_3x3_blur_stream_unit] ERROR");
        $finish;
    end

endmodule
